/* rtl/ddo_pkg.sv */
// Shared types, codes and fixed-point constants of the differential drive odometry core.
package ddo_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_DISTANCE_SCALE = 2'd0;
    localparam logic [1:0] REG_START_X        = 2'd1;
    localparam logic [1:0] REG_START_Y        = 2'd2;

    // Phases of one shared multiply: latch magnitudes, low chunk, high chunk, sum, write back
    typedef logic [2:0] t_phase;
    localparam t_phase PH_LATCH = 3'd0;
    localparam t_phase PH_LO    = 3'd1;
    localparam t_phase PH_HI    = 3'd2;
    localparam t_phase PH_SUM   = 3'd3;
    localparam t_phase PH_WB    = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_TRAVEL,
        ST_ANGLE,
        ST_SQUARE,
        ST_POLY7,
        ST_POLY5,
        ST_POLY3,
        ST_POLY1,
        ST_SINE,
        ST_MOVE_X,
        ST_MOVE_Y,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_TRAVEL,
        OP_ANGLE,
        OP_SQUARE,
        OP_POLY7,
        OP_POLY5,
        OP_POLY3,
        OP_POLY1,
        OP_SINE,
        OP_MOVE_X,
        OP_MOVE_Y
    } t_op;

    typedef struct packed {
        t_op    op;
        t_phase phase;
        logic   cos;
        logic   take_in;
        logic   load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clr;
    } t_dp_status;

    // Q30 odd polynomial of sin(pi/2 * t), with the sign of each Horner step folded in
    localparam logic signed [34:0] SC9     = 35'sd172272;
    localparam logic signed [34:0] C_POLY7 = -35'sd5026995;
    localparam logic signed [34:0] C_POLY5 = 35'sd85569306;
    localparam logic signed [34:0] C_POLY3 = -35'sd693598668;
    localparam logic signed [34:0] C_POLY1 = 35'sd1686629713;
    localparam logic [32:0]        Q30_ONE = 33'd1073741824;

    localparam logic [47:0] MAX48_U = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] MIN48_U = 48'h8000_0000_0000;

    localparam logic signed [51:0] SAT_MAX = 52'sd140737488355327;
    localparam logic signed [51:0] SAT_MIN = -52'sd140737488355328;

    function automatic logic [47:0] sat48(input logic signed [51:0] v);
        logic [47:0] res;
        if (v > SAT_MAX) begin
            res = MAX48_U;
        end else if (v < SAT_MIN) begin
            res = MIN48_U;
        end else begin
            res = v[47:0];
        end
        return res;
    endfunction

endpackage

/* rtl/ddo_ctrl.sv */
// Sequencer of the odometry core: handshakes and the order of datapath operations.
module ddo_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  ddo_pkg::t_dp_status i_status,
    output ddo_pkg::t_dp_cmd    o_cmd
);
    import ddo_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_cos, n_cos;
    logic   r_out_valid, n_out_valid;
    logic   mul_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_LATCH;
            r_cos       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_cos       <= n_cos;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_phase          = r_phase;
        n_cos            = r_cos;
        n_out_valid      = r_out_valid;
        o_cmd.op         = OP_NONE;
        o_cmd.phase      = r_phase;
        o_cmd.cos        = r_cos;
        o_cmd.take_in    = 1'b0;
        o_cmd.load_out   = 1'b0;
        mul_done         = (r_phase == PH_WB);

        // drop the word once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (r_state inside {ST_TRAVEL, ST_SQUARE, ST_POLY7, ST_POLY5, ST_POLY3, ST_POLY1,
                            ST_SINE, ST_MOVE_X, ST_MOVE_Y}) begin
            n_phase = mul_done ? PH_LATCH : r_phase + 3'd1;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    n_state       = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.op = OP_LOAD;
                n_cos    = 1'b0;
                n_state  = i_status.clr ? ST_DONE : ST_TRAVEL;
            end
            ST_TRAVEL: begin
                o_cmd.op = OP_TRAVEL;
                if (mul_done) n_state = ST_ANGLE;
            end
            ST_ANGLE: begin
                o_cmd.op = OP_ANGLE;
                n_state  = ST_SQUARE;
            end
            ST_SQUARE: begin
                o_cmd.op = OP_SQUARE;
                if (mul_done) n_state = ST_POLY7;
            end
            ST_POLY7: begin
                o_cmd.op = OP_POLY7;
                if (mul_done) n_state = ST_POLY5;
            end
            ST_POLY5: begin
                o_cmd.op = OP_POLY5;
                if (mul_done) n_state = ST_POLY3;
            end
            ST_POLY3: begin
                o_cmd.op = OP_POLY3;
                if (mul_done) n_state = ST_POLY1;
            end
            ST_POLY1: begin
                o_cmd.op = OP_POLY1;
                if (mul_done) n_state = ST_SINE;
            end
            ST_SINE: begin
                o_cmd.op = OP_SINE;
                if (mul_done) begin
                    // second pass evaluates the cosine
                    n_cos   = !r_cos;
                    n_state = r_cos ? ST_MOVE_X : ST_ANGLE;
                end
            end
            ST_MOVE_X: begin
                o_cmd.op = OP_MOVE_X;
                if (mul_done) n_state = ST_MOVE_Y;
            end
            ST_MOVE_Y: begin
                o_cmd.op = OP_MOVE_Y;
                if (mul_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_phase = PH_LATCH;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/ddo_datapath.sv */
// Datapath of the odometry core: pose state, sine polynomial and a shared 24x32 multiplier.
module ddo_datapath #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ddo_pkg::t_dp_cmd    i_cmd,
    output ddo_pkg::t_dp_status o_status,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [47:0]         i_cfg_data,
    input  logic signed [31:0]  i_left_position,
    input  logic signed [31:0]  i_right_position,
    input  logic [15:0]         i_heading_in,
    input  logic                i_clear,
    output logic signed [47:0]  o_x_out,
    output logic signed [47:0]  o_y_out,
    output logic [15:0]         o_heading_out,
    output logic signed [47:0]  o_step_distance,
    output logic signed [47:0]  o_total_out
);
    import ddo_pkg::*;

    localparam int T_SHIFT = 32 - ANGLE_BITS;
    localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};
    localparam logic [ANGLE_BITS-2:0] QUARTER_U = {1'b1, {(ANGLE_BITS-2){1'b0}}};

    // configuration and pose state
    logic [31:0] r_scale;
    logic [47:0] r_start_x, r_start_y;
    logic [31:0] r_last_l, r_last_r;
    logic [47:0] r_x, r_y, r_total;

    // latched word and working registers
    logic [31:0]        r_lp, r_rp;
    logic [15:0]        r_hd;
    logic               r_clr;
    logic signed [32:0] r_sum;
    logic signed [47:0] r_travel;
    logic [30:0]        r_t, r_t2;
    logic signed [34:0] r_p;
    logic               r_quad;
    logic signed [33:0] r_sin, r_cos;
    logic [47:0]        r_ma;
    logic [31:0]        r_mb;
    logic               r_neg;
    logic [55:0]        r_pp0, r_pp1;
    logic [79:0]        r_mag;

    // output word
    logic [47:0] r_o_x, r_o_y, r_o_step, r_o_total;
    logic [15:0] r_o_hd;

    logic [31:0]        dl, dr;
    logic signed [32:0] n_sum;
    logic signed [48:0] a_src, a_abs;
    logic signed [33:0] b_src, b_abs;
    logic [23:0]        mul_chunk;
    logic [55:0]        mul_prod;
    logic               is_mul;

    logic [31:0]             ang_wide;
    logic [ANGLE_BITS-1:0]   ang;
    logic [ANGLE_BITS-3:0]   ang_rem;
    logic [ANGLE_BITS-2:0]   ang_u;
    logic [30:0]             n_t;

    logic [78:0]        half;
    logic [47:0]        lim;
    logic [47:0]        n_travel;
    logic [49:0]        m30;
    logic signed [51:0] xe, ye, me, te, tre, x_sum, y_sum, t_sum;
    logic signed [34:0] coef, pe, n_p;
    logic [32:0]        sv;
    logic               fneg;
    logic signed [33:0] n_s;

    // encoder deltas wrap at 32 bits
    assign dl    = r_lp - r_last_l;
    assign dr    = r_rp - r_last_r;
    assign n_sum = {dl[31], dl} + {dr[31], dr};

    assign is_mul = i_cmd.op inside {OP_TRAVEL, OP_SQUARE, OP_POLY7, OP_POLY5, OP_POLY3,
                                     OP_POLY1, OP_SINE, OP_MOVE_X, OP_MOVE_Y};

    always_comb begin
        case (i_cmd.op)
            OP_TRAVEL: begin
                a_src = {{16{r_sum[32]}}, r_sum};
                b_src = {2'b00, r_scale};
            end
            OP_SQUARE: begin
                a_src = {18'd0, r_t};
                b_src = {3'd0, r_t};
            end
            OP_POLY7, OP_POLY5, OP_POLY3, OP_POLY1: begin
                a_src = {{14{r_p[34]}}, r_p};
                b_src = {3'd0, r_t2};
            end
            OP_SINE: begin
                a_src = {{14{r_p[34]}}, r_p};
                b_src = {3'd0, r_t};
            end
            OP_MOVE_X: begin
                a_src = {r_travel[47], r_travel};
                b_src = r_sin;
            end
            OP_MOVE_Y: begin
                a_src = {r_travel[47], r_travel};
                b_src = r_cos;
            end
            default: begin
                a_src = '0;
                b_src = '0;
            end
        endcase
    end

    assign a_abs     = a_src[48] ? (49'sd0 - a_src) : a_src;
    assign b_abs     = b_src[33] ? (34'sd0 - b_src) : b_src;
    assign mul_chunk = (i_cmd.phase == PH_LO) ? r_ma[23:0] : r_ma[47:24];
    assign mul_prod  = {32'd0, mul_chunk} * {24'd0, r_mb};

    // angle folding into the first quadrant
    assign ang_wide = {16'd0, r_hd};
    assign ang      = ang_wide[ANGLE_BITS-1:0] + (i_cmd.cos ? QUARTER : '0);
    assign ang_rem  = ang[ANGLE_BITS-3:0];
    assign ang_u    = ang[ANGLE_BITS-2] ? (QUARTER_U - {1'b0, ang_rem}) : {1'b0, ang_rem};
    assign n_t      = 31'(ang_u) << T_SHIFT;

    // travel: half the scaled sum, saturated to 48 bits
    assign half = r_mag[79:1];
    always_comb begin
        if (r_neg) begin
            lim = (half > {31'd0, MIN48_U}) ? MIN48_U : half[47:0];
        end else begin
            lim = (half > {31'd0, MAX48_U}) ? MAX48_U : half[47:0];
        end
    end
    assign n_travel = r_neg ? (48'd0 - lim) : lim;

    // Q30 product magnitude and its uses
    assign m30   = r_mag[79:30];
    assign me    = {2'b00, m30};
    assign xe    = {{4{r_x[47]}}, r_x};
    assign ye    = {{4{r_y[47]}}, r_y};
    assign te    = {{4{r_total[47]}}, r_total};
    assign tre   = {{4{r_travel[47]}}, r_travel};
    assign x_sum = r_neg ? (xe - me) : (xe + me);
    assign y_sum = r_neg ? (ye + me) : (ye - me);
    assign t_sum = te + tre;

    always_comb begin
        case (i_cmd.op)
            OP_POLY7: coef = C_POLY7;
            OP_POLY5: coef = C_POLY5;
            OP_POLY3: coef = C_POLY3;
            OP_POLY1: coef = C_POLY1;
            default:  coef = '0;
        endcase
    end
    assign pe  = {2'b00, m30[32:0]};
    assign n_p = r_neg ? (coef - pe) : (coef + pe);

    // clamp the sine at one, then apply the half-turn sign
    assign sv   = (!r_neg && (m30 > {17'd0, Q30_ONE})) ? Q30_ONE : m30[32:0];
    assign fneg = r_neg ^ r_quad;
    assign n_s  = fneg ? (34'sd0 - {1'b0, sv}) : {1'b0, sv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale   <= 32'(64'd1 << FRAC_BITS);
            r_start_x <= '0;
            r_start_y <= '0;
            r_last_l  <= '0;
            r_last_r  <= '0;
            r_x       <= '0;
            r_y       <= '0;
            r_total   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DISTANCE_SCALE: r_scale   <= i_cfg_data[31:0];
                    REG_START_X:        r_start_x <= i_cfg_data;
                    REG_START_Y:        r_start_y <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_LOAD) begin
                r_last_l <= r_lp;
                r_last_r <= r_rp;
                if (r_clr) begin
                    r_x     <= r_start_x;
                    r_y     <= r_start_y;
                    r_total <= '0;
                end
            end
            if (i_cmd.phase == PH_WB) begin
                if (i_cmd.op == OP_MOVE_X) begin
                    r_x     <= sat48(x_sum);
                    r_total <= sat48(t_sum);
                end
                if (i_cmd.op == OP_MOVE_Y) begin
                    r_y <= sat48(y_sum);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_lp  <= i_left_position;
            r_rp  <= i_right_position;
            r_hd  <= i_heading_in;
            r_clr <= i_clear;
        end
        if (i_cmd.op == OP_LOAD) begin
            r_sum <= n_sum;
            if (r_clr) r_travel <= '0;
        end
        if (i_cmd.op == OP_ANGLE) begin
            r_t    <= n_t;
            r_quad <= ang[ANGLE_BITS-1];
            r_p    <= SC9;
        end
        if (is_mul) begin
            case (i_cmd.phase)
                PH_LATCH: begin
                    r_ma  <= a_abs[47:0];
                    r_mb  <= b_abs[31:0];
                    r_neg <= a_src[48] ^ b_src[33];
                end
                PH_LO:  r_pp0 <= mul_prod;
                PH_HI:  r_pp1 <= mul_prod;
                PH_SUM: r_mag <= {24'd0, r_pp0} + {r_pp1, 24'd0};
                PH_WB: begin
                    case (i_cmd.op)
                        OP_TRAVEL: r_travel <= n_travel;
                        OP_SQUARE: r_t2     <= m30[30:0];
                        OP_POLY7, OP_POLY5, OP_POLY3, OP_POLY1: r_p <= n_p;
                        OP_SINE: begin
                            if (i_cmd.cos) r_cos <= n_s;
                            else           r_sin <= n_s;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        if (i_cmd.load_out) begin
            r_o_x     <= r_x;
            r_o_y     <= r_y;
            r_o_hd    <= r_hd;
            r_o_step  <= r_travel;
            r_o_total <= r_total;
        end
    end

    assign o_status.clr    = r_clr;
    assign o_x_out         = r_o_x;
    assign o_y_out         = r_o_y;
    assign o_heading_out   = r_o_hd;
    assign o_step_distance = r_o_step;
    assign o_total_out     = r_o_total;

endmodule

/* rtl/differential_drive_odometry_core.sv */
// Top level of the differential drive dead-reckoning odometry core.
// Each input word carries both wheel encoder positions, a heading (full turn 2^ANGLE_BITS,
// from the negative y axis toward the positive x axis) and a clear flag; each produces one
// output word with the new pose, the step travel and the running total, all signed Q16 and
// saturated to 48 bits, and the heading. A clear word loads start_x/start_y, zeroes the total
// and latches the encoders. In a motion word every product runs through one shared 24x32
// multiplier in its latch, low chunk, high chunk, sum and write-back phases, and a word needs
// 15 products (travel, two degree-9 sine polynomials for sine and cosine, and the x and y
// updates). The input is stalled while a word is in work; a finished word waits in the output
// register, and the next input word is taken in the cycle after the previous result is
// loaded, so no new word is taken before the last one is through. If the output register
// is still held by the sink, the finished word waits in the core and the input stays stalled.
// Configuration writes are taken at any time but must only be issued while the core is idle.
module differential_drive_odometry_core #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_left_position,
    input  logic signed [31:0] i_right_position,
    input  logic [15:0]        i_heading_in,
    input  logic               i_clear,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [47:0] o_x_out,
    output logic signed [47:0] o_y_out,
    output logic [15:0]        o_heading_out,
    output logic signed [47:0] o_step_distance,
    output logic signed [47:0] o_total_out
);
    import ddo_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    ddo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ddo_datapath #(
        .ANGLE_BITS (ANGLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_left_position  (i_left_position),
        .i_right_position (i_right_position),
        .i_heading_in     (i_heading_in),
        .i_clear          (i_clear),
        .o_x_out          (o_x_out),
        .o_y_out          (o_y_out),
        .o_heading_out    (o_heading_out),
        .o_step_distance  (o_step_distance),
        .o_total_out      (o_total_out)
    );

endmodule

/* sim/tb_differential_drive_odometry_core.sv */
// Testbench of the odometry core: directed table plus random words, checked against typed poses or a pose predictor.
module tb_differential_drive_odometry_core;
    import ddo_pkg::*;

    localparam int     DRAIN_CYCLES = 100;
    localparam int     HOLD_CYCLES  = 500;
    localparam int     RAND_WORDS   = 100;
    localparam int     PHASES       = 6;
    localparam longint POS_MAX      = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint POS_MIN      = -64'sh0000_8000_0000_0000;
    localparam longint Q30_UNIT     = 64'sd1073741824;
    // Odd Horner coefficients of the quarter-wave sine, Q30
    localparam longint K1 = 64'sd1686629713;
    localparam longint K3 = 64'sd693598668;
    localparam longint K5 = 64'sd85569306;
    localparam longint K7 = 64'sd5026995;
    localparam longint K9 = 64'sd172272;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic [15:0]        heading;
        logic               clear;
    } t_odo_in;

    typedef struct packed {
        logic signed [47:0] x;
        logic signed [47:0] y;
        logic [15:0]        heading;
        logic signed [47:0] step;
        logic signed [47:0] total;
    } t_pose;

    typedef enum logic { ROW_WORD, ROW_CFG } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  idx;
        logic [47:0] data;
        t_odo_in     w;
        logic        typed;
        t_pose       want;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = '0;
    logic [47:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [31:0] i_left_position = '0;
    logic signed [31:0] i_right_position = '0;
    logic [15:0]        i_heading_in = '0;
    logic               i_clear = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [47:0] o_x_out;
    logic signed [47:0] o_y_out;
    logic [15:0]        o_heading_out;
    logic signed [47:0] o_step_distance;
    logic signed [47:0] o_total_out;

    // Predictor state and shadow registers
    logic [31:0] scale_r = 32'd65536;
    longint      start_x_r = 0;
    longint      start_y_r = 0;
    logic [31:0] prev_left = '0;
    logic [31:0] prev_right = '0;
    longint      pose_x = 0;
    longint      pose_y = 0;
    longint      dist_total = 0;

    t_pose pose_due_q[$];
    t_row  dir_table[$];
    int    mismatches = 0;
    int    src_idle_pct = 0;
    int    snk_stall_pct = 0;
    int    hold_req = 0;
    int    hold_seen = 0;
    int    hold_left = 0;

    differential_drive_odometry_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_left_position (i_left_position),
        .i_right_position(i_right_position),
        .i_heading_in    (i_heading_in),
        .i_clear         (i_clear),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_x_out         (o_x_out),
        .o_y_out         (o_y_out),
        .o_heading_out   (o_heading_out),
        .o_step_distance (o_step_distance),
        .o_total_out     (o_total_out)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint clamp48(longint v);
        longint r;
        r = v;
        if (v > POS_MAX) r = POS_MAX;
        if (v < POS_MIN) r = POS_MIN;
        return r;
    endfunction

    // a * s / 2^30, truncated toward zero
    function automatic longint q30_mul(longint a, longint s);
        logic [63:0] ma;
        logic [63:0] ms;
        logic [95:0] prod;
        longint      r;
        ma = (a < 0) ? -a : a;
        ms = (s < 0) ? -s : s;
        prod = ma * ms;
        r = longint'(prod[93:30]);
        return ((a < 0) != (s < 0)) ? -r : r;
    endfunction

    function automatic longint sine_q30(logic [15:0] ang);
        logic [1:0]  quad;
        logic [13:0] frac;
        logic [14:0] u;
        longint      t;
        longint      t2;
        longint      p;
        longint      s;
        quad = ang[15:14];
        frac = ang[13:0];
        // mirror the odd quadrants
        u = quad[0] ? (15'd16384 - {1'b0, frac}) : {1'b0, frac};
        t = 64'(u) << 16;
        t2 = q30_mul(t, t);
        p = K9;
        p = q30_mul(p, t2) - K7;
        p = q30_mul(p, t2) + K5;
        p = q30_mul(p, t2) - K3;
        p = q30_mul(p, t2) + K1;
        s = q30_mul(p, t);
        if (s > Q30_UNIT) s = Q30_UNIT;
        return quad[1] ? -s : s;
    endfunction

    function automatic t_pose predict_pose(t_odo_in w);
        logic signed [31:0] dl;
        logic signed [31:0] dr;
        longint             sum;
        longint             travel;
        logic [63:0]        mag;
        logic [63:0]        half;
        logic [15:0]        ang_cos;
        t_pose              r;
        travel = 0;
        if (w.clear) begin
            pose_x = start_x_r;
            pose_y = start_y_r;
            dist_total = 0;
        end else begin
            dl = w.left - prev_left;
            dr = w.right - prev_right;
            sum = longint'(dl) + longint'(dr);
            mag = (sum < 0) ? -sum : sum;
            half = (mag * {32'd0, scale_r}) >> 1;
            if (sum < 0) begin
                travel = (half > 64'h0000_8000_0000_0000) ? POS_MIN : -longint'(half);
            end else begin
                travel = (half > 64'h0000_7FFF_FFFF_FFFF) ? POS_MAX : longint'(half);
            end
            ang_cos = w.heading + 16'd16384;
            pose_x = clamp48(pose_x + q30_mul(travel, sine_q30(w.heading)));
            pose_y = clamp48(pose_y - q30_mul(travel, sine_q30(ang_cos)));
            dist_total = clamp48(dist_total + travel);
        end
        prev_left = w.left;
        prev_right = w.right;
        r.x = 48'(pose_x);
        r.y = 48'(pose_y);
        r.heading = w.heading;
        r.step = 48'(travel);
        r.total = 48'(dist_total);
        return r;
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[47:0];
    endfunction

    // Mostly plausible motion from the last accepted reading, with clears and jumps mixed in
    function automatic t_odo_in rand_word();
        t_odo_in w;
        int      mode;
        mode = $urandom_range(99);
        w.clear = 1'b0;
        w.heading = ($urandom_range(9) == 0) ? 16'(16'($urandom_range(3)) << 14)
                                             : 16'($urandom_range(65535));
        if (mode < 5) begin
            w.clear = 1'b1;
            w.left = $urandom;
            w.right = $urandom;
        end else if (mode < 60) begin
            w.left = prev_left + 32'(int'($urandom_range(2000)) - 1000);
            w.right = prev_right + 32'(int'($urandom_range(2000)) - 1000);
        end else if (mode < 80) begin
            w.left = prev_left + 32'(int'($urandom_range(2097152)) - 1048576);
            w.right = prev_right + 32'(int'($urandom_range(2097152)) - 1048576);
        end else if (mode < 90) begin
            w.left = $urandom;
            w.right = $urandom;
        end else begin
            w.left = prev_left;
            w.right = prev_right;
        end
        return w;
    endfunction

    task automatic add_word(logic [31:0] left, logic [31:0] right, logic [15:0] hd, logic clr);
        t_row r;
        r = '0;
        r.kind = ROW_WORD;
        r.w = '{left, right, hd, clr};
        dir_table.push_back(r);
    endtask

    task automatic add_check(logic [31:0] left, logic [31:0] right, logic [15:0] hd, logic clr,
                             longint ex, longint ey, longint es, longint et);
        t_row r;
        r = '0;
        r.kind = ROW_WORD;
        r.w = '{left, right, hd, clr};
        r.typed = 1'b1;
        r.want = '{48'(ex), 48'(ey), hd, 48'(es), 48'(et)};
        dir_table.push_back(r);
    endtask

    task automatic add_cfg(logic [1:0] idx, logic [47:0] data);
        t_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        dir_table.push_back(r);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [47:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_DISTANCE_SCALE: scale_r = data[31:0];
            REG_START_X:        start_x_r = longint'($signed(data));
            REG_START_Y:        start_y_r = longint'($signed(data));
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait out every pending pose, then let the core go idle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pose_due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_word(t_odo_in w, logic typed, t_pose typed_pose);
        int    gaps;
        t_pose p;
        gaps = 0;
        while ($urandom_range(99) < src_idle_pct) gaps++;
        if (gaps > 0) begin
            i_in_valid <= 1'b0;
            repeat (gaps) @(posedge i_clk);
        end
        i_left_position <= w.left;
        i_right_position <= w.right;
        i_heading_in <= w.heading;
        i_clear <= w.clear;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        p = predict_pose(w);
        pose_due_q.push_back(typed ? typed_pose : p);
    endtask

    task automatic cmp48(string name, logic signed [47:0] want, logic signed [47:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_pose();
        t_pose want;
        if (pose_due_q.size() == 0) begin
            $display("%0t: unexpected pose word, expected none, got x=%0d y=%0d", $time,
                     o_x_out, o_y_out);
            mismatches++;
        end else begin
            want = pose_due_q.pop_front();
            cmp48("x_out", want.x, o_x_out);
            cmp48("y_out", want.y, o_y_out);
            cmp48("step_distance", want.step, o_step_distance);
            cmp48("total_out", want.total, o_total_out);
            if (want.heading !== o_heading_out) begin
                $display("%0t: heading_out mismatch, expected %0d, got %0d", $time,
                         want.heading, o_heading_out);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_pose();
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < snk_stall_pct);
        end
    end

    initial begin
        #20_000_000;
        $display("tb_differential_drive_odometry_core: FAIL");
        $finish;
    end

    initial begin
        // Cardinal headings at unit scale, then wraps, clears and saturation
        add_check(0, 0, 16'd0, 1'b0, 0, 0, 0, 0);
        add_check(1, 1, 16'd0, 1'b0, 0, -65536, 65536, 65536);
        add_check(2, 2, 16'd16384, 1'b0, 65536, -65536, 65536, 131072);
        add_check(3, 3, 16'd32768, 1'b0, 65536, 0, 65536, 196608);
        add_check(4, 4, 16'd49152, 1'b0, 0, 0, 65536, 262144);
        add_check(3, 3, 16'd0, 1'b0, 0, 65536, -65536, 196608);
        add_word(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b0);
        add_word(32'h8000_0000, 32'h7FFF_FFFF, 16'h2000, 1'b0);
        add_word(32'hFFFF_FFFF, 32'h0000_0000, 16'h0001, 1'b0);
        add_check(32'h7FFF_FFF0, 32'h8000_0010, 16'd1234, 1'b1, 0, 0, 0, 0);
        add_check(32'h8000_0010, 32'h8000_0030, 16'd0, 1'b0, 0, -2097152, 2097152, 2097152);
        add_cfg(REG_UNMAPPED, 48'hFFFF_FFFF_FFFF);
        add_word(32'h8000_0410, 32'h8000_0130, 16'h1234, 1'b0);
        add_cfg(REG_DISTANCE_SCALE, 48'h0000_FFFF_FFFF);
        add_cfg(REG_START_X, 48'(POS_MAX));
        add_cfg(REG_START_Y, 48'(POS_MIN));
        add_check(0, 0, 16'h5555, 1'b1, POS_MAX, POS_MIN, 0, 0);
        add_check(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h2000, 1'b0, POS_MAX, POS_MIN, POS_MAX,
                  POS_MAX);
        add_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h6000, 1'b0);
        add_cfg(REG_DISTANCE_SCALE, 48'd0);
        add_word(32'h0001_2345, 32'hFFFE_0000, 16'hA000, 1'b0);
        add_cfg(REG_START_X, 48'(POS_MIN));
        add_cfg(REG_START_Y, 48'(POS_MAX));
        add_check(32'h0000_0001, 32'hFFFF_FFFF, 16'hC000, 1'b1, POS_MIN, POS_MAX, 0, 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[k]) begin
            if (dir_table[k].kind == ROW_CFG) begin
                settle();
                cfg_write(dir_table[k].idx, dir_table[k].data);
            end else begin
                send_word(dir_table[k].w, dir_table[k].typed, dir_table[k].want);
            end
        end
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct = 0;  snk_stall_pct = 0;
                    cfg_write(REG_DISTANCE_SCALE, 48'd65536);
                    cfg_write(REG_START_X, 48'd0);
                    cfg_write(REG_START_Y, 48'd0);
                end
                1: begin
                    src_idle_pct = 88; snk_stall_pct = 0;
                    cfg_write(REG_DISTANCE_SCALE, 48'($urandom_range(1 << 18)));
                    cfg_write(REG_START_X, rand48());
                    cfg_write(REG_START_Y, rand48());
                end
                2: begin
                    src_idle_pct = 0;  snk_stall_pct = 88;
                    cfg_write(REG_DISTANCE_SCALE, 48'h0000_FFFF_FFFF);
                    cfg_write(REG_START_X, 48'(POS_MAX));
                    cfg_write(REG_START_Y, 48'(POS_MIN));
                end
                3: begin
                    src_idle_pct = 7;  snk_stall_pct = 7;
                    cfg_write(REG_DISTANCE_SCALE, 48'd0);
                    cfg_write(REG_START_X, 48'(POS_MIN));
                    cfg_write(REG_START_Y, 48'(POS_MAX));
                end
                4: begin
                    src_idle_pct = 0;  snk_stall_pct = 0;
                    cfg_write(REG_DISTANCE_SCALE, 48'($urandom));
                    cfg_write(REG_START_X, 48'(int'($urandom_range(2000000)) - 1000000));
                    cfg_write(REG_START_Y, 48'(int'($urandom_range(2000000)) - 1000000));
                end
                default: begin
                    src_idle_pct = 7;  snk_stall_pct = 7;
                    cfg_write(REG_DISTANCE_SCALE, 48'(1 + $urandom_range(262140)));
                    cfg_write(REG_START_X, rand48());
                    cfg_write(REG_START_Y, rand48());
                end
            endcase
            // hold off the output long enough for the core to back up its input
            if (ph == 0) hold_req <= hold_req + 1;
            repeat (RAND_WORDS) send_word(rand_word(), 1'b0, '0);
            settle();
        end

        if (mismatches == 0) begin
            $display("tb_differential_drive_odometry_core: PASS");
        end else begin
            $display("tb_differential_drive_odometry_core: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/ddo_pkg.sv
rtl/ddo_ctrl.sv
rtl/ddo_datapath.sv
rtl/differential_drive_odometry_core.sv
sim/tb_differential_drive_odometry_core.sv
